// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes, types and index helper of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   localparam int OP_W   = 3;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int POS_W  = 11;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;
   localparam int SPAN_W = ROW_W + COL_W;

   localparam int REQ_BITS = OP_W + CHAR_W + ROW_W + COL_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = ROW_W + COL_W + POS_W + CELL_W + 1;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_PUT_CHAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUT_AT    = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_CURS  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
   localparam logic [OP_W-1:0] OP_ERASE_BS  = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_CELL = 3'd5;

   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

   localparam logic [COL_W:0] TAB_STEP = 8'd8;
   localparam logic [COL_W:0] TAB_MASK = 8'hF8;

   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

   localparam int SRC_W = 2;
   localparam logic [SRC_W-1:0] SRC_COPY  = 2'd0;
   localparam logic [SRC_W-1:0] SRC_ATTR  = 2'd1;
   localparam logic [SRC_W-1:0] SRC_RESET = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  target_row;
      logic [COL_W-1:0]  target_col;
   } request_type;

   typedef struct packed {
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_data;
      logic              rejected;
   } result_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [SRC_W-1:0]  src;
   } write_type;

   function automatic logic [SPAN_W-1:0] cell_span(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      cell_span = SPAN_W'(row) * SPAN_W'(COLUMNS) + SPAN_W'(col);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor, cell writes, reads and scroll/clear walks.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire tcw_pkg::request_type        req,
   input  wire logic [tcw_pkg::ATTR_W-1:0]  color_attr,
   output logic                             res_valid,
   input  wire logic                        res_ready,
   output tcw_pkg::result_type              res
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   localparam int AW = tcw_pkg::ADDR_W;
   localparam int RW = tcw_pkg::ROW_W;
   localparam int CW = tcw_pkg::COL_W;

   logic [1:0]                       state_ff, state_in;
   logic [RW-1:0]                    cur_row_ff, cur_row_in;
   logic [CW-1:0]                    cur_col_ff, cur_col_in;
   logic [AW-1:0]                    cnt_ff, cnt_in;
   logic [tcw_pkg::SRC_W-1:0]        kind_ff, kind_in;
   tcw_pkg::write_type               wr_ff, wr_in;
   logic                             res_valid_ff, res_valid_in;
   logic [tcw_pkg::CELL_W-1:0]       cell_ff, cell_in;
   logic                             rej_ff, rej_in;

   logic                             accept;
   logic                             on_grid;
   logic [AW-1:0]                    tgt_idx;
   logic [AW-1:0]                    cur_idx;
   logic [AW-1:0]                    left_idx;
   logic [RW-1:0]                    left_row;
   logic [CW-1:0]                    left_col;
   logic [RW:0]                      put_row;
   logic [CW:0]                      put_col;
   logic [CW:0]                      tab_col;
   logic [CW:0]                      inc_col;
   logic                             put_write;
   logic                             put_scroll;
   logic                             dw_en;
   logic [AW-1:0]                    dw_addr;
   logic [tcw_pkg::CELL_W-1:0]       dw_data;
   logic                             mem_we;
   logic [AW-1:0]                    mem_waddr;
   logic [tcw_pkg::CELL_W-1:0]       mem_wdata;
   logic [AW-1:0]                    mem_raddr;
   logic [tcw_pkg::CELL_W-1:0]       mem_rdata;
   logic [tcw_pkg::CELL_W-1:0]       blank;
   logic [tcw_pkg::SPAN_W-1:0]       cur_span;

   assign req_ready = (state_ff == ST_IDLE) && !res_valid_ff && !wr_ff.valid;
   assign accept    = req_valid && req_ready;
   assign blank     = {color_attr, tcw_pkg::CH_SPACE};

   assign on_grid = ({3'b000, req.target_row} < 8'(tcw_pkg::ROWS)) &&
                    ({1'b0, req.target_col} < 8'(tcw_pkg::COLUMNS));
   assign tgt_idx  = AW'(tcw_pkg::cell_span(req.target_row, req.target_col));
   assign cur_span = tcw_pkg::cell_span(cur_row_ff, cur_col_ff);
   assign cur_idx  = AW'(cur_span);
   assign left_idx = AW'(tcw_pkg::cell_span(left_row, left_col));

   always_comb begin
      left_row = cur_row_ff;
      left_col = cur_col_ff;
      if (cur_col_ff != '0) begin
         left_col = cur_col_ff - CW'(1);
      end else if (cur_row_ff != '0) begin
         left_row = cur_row_ff - RW'(1);
         left_col = CW'(tcw_pkg::COLUMNS - 1);
      end
   end

   assign tab_col = ({1'b0, cur_col_ff} + tcw_pkg::TAB_STEP) & tcw_pkg::TAB_MASK;
   assign inc_col = {1'b0, cur_col_ff} + (CW + 1)'(1);

   always_comb begin
      put_row    = {1'b0, cur_row_ff};
      put_col    = {1'b0, cur_col_ff};
      put_write  = 1'b0;
      put_scroll = 1'b0;
      case (req.char_code)
         tcw_pkg::CH_LF: begin
            put_col = '0;
            put_row = {1'b0, cur_row_ff} + (RW + 1)'(1);
         end
         tcw_pkg::CH_TAB: begin
            if (tab_col >= (CW + 1)'(tcw_pkg::COLUMNS)) begin
               put_col = '0;
               put_row = {1'b0, cur_row_ff} + (RW + 1)'(1);
            end else begin
               put_col = tab_col;
            end
         end
         tcw_pkg::CH_CR: begin
            put_col = '0;
         end
         tcw_pkg::CH_BS: begin
            put_row = {1'b0, left_row};
            put_col = {1'b0, left_col};
         end
         default: begin
            if (req.char_code >= tcw_pkg::CH_SPACE && req.char_code != tcw_pkg::CH_DEL) begin
               put_write = 1'b1;
               if (inc_col >= (CW + 1)'(tcw_pkg::COLUMNS)) begin
                  put_col = '0;
                  put_row = {1'b0, cur_row_ff} + (RW + 1)'(1);
               end else begin
                  put_col = inc_col;
               end
            end
         end
      endcase
      if (put_row == (RW + 1)'(tcw_pkg::ROWS)) begin
         put_scroll = 1'b1;
         put_row    = (RW + 1)'(tcw_pkg::ROWS - 1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      wr_in.valid  = 1'b0;
      wr_in.addr   = cnt_ff;
      wr_in.src    = kind_ff;
      res_valid_in = res_valid_ff && !res_ready;
      cell_in      = cell_ff;
      rej_in       = rej_ff;
      dw_en        = 1'b0;
      dw_addr      = cur_idx;
      dw_data      = {color_attr, req.char_code};
      mem_raddr    = tgt_idx;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cell_in = '0;
               rej_in  = 1'b0;
               case (req.operation)
                  tcw_pkg::OP_PUT_CHAR: begin
                     dw_en      = put_write;
                     cur_row_in = put_row[RW-1:0];
                     cur_col_in = put_col[CW-1:0];
                     if (put_scroll) begin
                        state_in = ST_WALK;
                        kind_in  = tcw_pkg::SRC_COPY;
                        cnt_in   = '0;
                     end else begin
                        res_valid_in = 1'b1;
                     end
                  end
                  tcw_pkg::OP_PUT_AT: begin
                     dw_en        = on_grid;
                     dw_addr      = tgt_idx;
                     rej_in       = !on_grid;
                     res_valid_in = 1'b1;
                  end
                  tcw_pkg::OP_SET_CURS: begin
                     if (on_grid) begin
                        cur_row_in = req.target_row;
                        cur_col_in = req.target_col;
                     end
                     rej_in       = !on_grid;
                     res_valid_in = 1'b1;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     cur_row_in = '0;
                     cur_col_in = '0;
                     state_in   = ST_WALK;
                     kind_in    = tcw_pkg::SRC_ATTR;
                     cnt_in     = '0;
                  end
                  tcw_pkg::OP_ERASE_BS: begin
                     cur_row_in   = left_row;
                     cur_col_in   = left_col;
                     dw_en        = 1'b1;
                     dw_addr      = left_idx;
                     dw_data      = blank;
                     res_valid_in = 1'b1;
                  end
                  tcw_pkg::OP_READ_CELL: begin
                     if (on_grid) begin
                        state_in = ST_READ;
                     end else begin
                        rej_in       = 1'b1;
                        res_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     res_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            mem_raddr   = cnt_ff + AW'(tcw_pkg::COLUMNS);
            wr_in.valid = 1'b1;
            if (kind_ff == tcw_pkg::SRC_COPY &&
                cnt_ff >= AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS)) begin
               wr_in.src = tcw_pkg::SRC_ATTR;
            end
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == AW'(tcw_pkg::CELLS - 1)) begin
               state_in     = ST_IDLE;
               res_valid_in = (kind_ff != tcw_pkg::SRC_RESET);
            end
         end
         ST_READ: begin
            cell_in      = mem_rdata;
            res_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_we    = wr_ff.valid;
      mem_waddr = wr_ff.addr;
      case (wr_ff.src)
         tcw_pkg::SRC_COPY: mem_wdata = mem_rdata;
         tcw_pkg::SRC_ATTR: mem_wdata = blank;
         default:           mem_wdata = tcw_pkg::RESET_CELL;
      endcase
      if (dw_en) begin
         mem_we    = 1'b1;
         mem_waddr = dw_addr;
         mem_wdata = dw_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WALK;
         kind_ff      <= tcw_pkg::SRC_RESET;
         cnt_ff       <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         wr_ff        <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         wr_ff        <= wr_in;
         res_valid_ff <= res_valid_in;
      end
      cell_ff <= cell_in;
      rej_ff  <= rej_in;
   end

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (tcw_pkg::CELLS)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign res_valid      = res_valid_ff;
   assign res.cursor_row = cur_row_ff;
   assign res.cursor_col = cur_col_ff;
   assign res.cursor_pos = cur_span[tcw_pkg::POS_W-1:0];
   assign res.cell_data  = cell_ff;
   assign res.rejected   = rej_ff;

endmodule

`default_nettype wire

// ----- rtl/core/text_console_writer_unit.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console engine: character grid in RAM, cursor, scroll and clear.
// ----------------------------------------------------------------------------
// Channel  Direction  Transfer when             Contents
// req      in         req_tvalid & req_tready   one console command
// rsp      out        rsp_tvalid & rsp_tready   cursor, cell, reject flag
// csr      in         csr_valid & csr_ready     attribute byte
//
// Put-char without scroll, set-cursor, put-at, erase and unused commands
// register their result directly; a cell read first waits for the RAM data.
// Clear and scroll walk every cell of the screen RAM, one per cycle, set by
// the single RAM write port. After reset a clearing pass runs, req_tready low.
// A result waiting in the output register does not hold off the next command.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // operation[2:0], char_code[10:3], target_row[15:11], target_col[22:16]
   input  wire logic [tcw_pkg::REQ_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // cursor_row[4:0], cursor_col[11:5], cursor_pos[22:12],
   // cell_data[38:23], rejected[39]
   output logic      [tcw_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [tcw_pkg::ATTR_W-1:0]  csr_data
);

   tcw_pkg::request_type            req;
   tcw_pkg::result_type             res;
   logic                            res_valid;
   logic                            res_ready;
   logic [tcw_pkg::ATTR_W-1:0]      color_attr_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   assign req.operation  = req_tdata[2:0];
   assign req.char_code  = req_tdata[10:3];
   assign req.target_row = req_tdata[15:11];
   assign req.target_col = req_tdata[22:16];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_attr_ff <= 8'h07;
      end else if (csr_valid && csr_ready) begin
         color_attr_ff <= csr_data;
      end
   end

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .color_attr (color_attr_ff),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = tcw_pkg::RSP_W'({res.rejected, res.cell_data, res.cursor_pos,
                                         res.cursor_col, res.cursor_row});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- test/text_console_writer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// Self-checking bench for the text console engine. Console commands and
// attribute writes are queued up front and driven on the falling edge; each
// command transfer runs through a behavioral screen and cursor model, and
// every result transfer is compared field by field with the oldest predicted
// cursor report. Both channels stall in random bursts except in calm phases.
// ----------------------------------------------------------------------------

module text_console_writer_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [tcw_pkg::OP_W-1:0] OP_NOP_LO = 3'd6;
   localparam logic [tcw_pkg::OP_W-1:0] OP_NOP_HI = 3'd7;

   localparam int STALL_LIMIT  = 25000;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 75;
   localparam int SHOW_LIMIT   = 10;

   typedef struct packed {
      logic [tcw_pkg::OP_W-1:0]   op;
      logic [tcw_pkg::CHAR_W-1:0] ch;
      logic [tcw_pkg::ROW_W-1:0]  row;
      logic [tcw_pkg::COL_W-1:0]  col;
   } console_cmd_type;

   typedef struct packed {
      logic [tcw_pkg::ROW_W-1:0]  row;
      logic [tcw_pkg::COL_W-1:0]  col;
      logic [tcw_pkg::POS_W-1:0]  pos;
      logic [tcw_pkg::CELL_W-1:0] cell_word;
      logic                       rejected;
   } cursor_report_type;

   typedef struct {
      bit                         attr_write;
      bit                         idle_ok;
      logic [tcw_pkg::ATTR_W-1:0] attr;
      console_cmd_type            cmd;
   } console_job_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [tcw_pkg::REQ_W-1:0]  req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [tcw_pkg::RSP_W-1:0]  rsp_tdata;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [tcw_pkg::ATTR_W-1:0] csr_data   = '0;

   console_job_type   pending_jobs[$];
   cursor_report_type reports_due[$];

   logic [tcw_pkg::CELL_W-1:0] screen_img[tcw_pkg::CELLS];
   int                         crow = 0;
   int                         ccol = 0;
   logic [tcw_pkg::ATTR_W-1:0] attr_now = 8'h07;

   bit req_done = 1'b0;
   bit csr_done = 1'b0;
   bit fill_idle = 1'b1;
   int gap_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int fault_count = 0;
   int cmd_count = 0;
   int rsp_count = 0;
   int scroll_count = 0;
   int clear_count = 0;
   int reject_count = 0;
   int attr_count = 0;

   text_console_writer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void blank_range(int first, int count);
      for (int i = first; i < first + count && i < tcw_pkg::CELLS; i++) begin
         screen_img[i] = {attr_now, tcw_pkg::CH_SPACE};
      end
   endfunction

   function automatic void step_left();
      if (ccol > 0) begin
         ccol--;
      end else if (crow > 0) begin
         crow--;
         ccol = tcw_pkg::COLUMNS - 1;
      end
   endfunction

   function automatic cursor_report_type console_apply(console_cmd_type c);
      cursor_report_type r;
      bit on_grid;
      int spot;
      on_grid = (c.row < tcw_pkg::ROWS) && (c.col < tcw_pkg::COLUMNS);
      spot = int'(c.row) * tcw_pkg::COLUMNS + int'(c.col);
      r = '0;
      case (c.op)
         tcw_pkg::OP_PUT_CHAR: begin
            if (c.ch == tcw_pkg::CH_LF) begin
               ccol = 0;
               crow++;
            end else if (c.ch == tcw_pkg::CH_TAB) begin
               ccol = (ccol / int'(tcw_pkg::TAB_STEP) + 1) * int'(tcw_pkg::TAB_STEP);
               if (ccol >= tcw_pkg::COLUMNS) begin
                  ccol = 0;
                  crow++;
               end
            end else if (c.ch == tcw_pkg::CH_CR) begin
               ccol = 0;
            end else if (c.ch == tcw_pkg::CH_BS) begin
               step_left();
            end else if (c.ch >= tcw_pkg::CH_SPACE && c.ch != tcw_pkg::CH_DEL) begin
               screen_img[crow * tcw_pkg::COLUMNS + ccol] = {attr_now, c.ch};
               ccol++;
               if (ccol >= tcw_pkg::COLUMNS) begin
                  ccol = 0;
                  crow++;
               end
            end
            if (crow >= tcw_pkg::ROWS) begin
               for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++) begin
                  screen_img[i] = screen_img[i + tcw_pkg::COLUMNS];
               end
               blank_range(tcw_pkg::CELLS - tcw_pkg::COLUMNS, tcw_pkg::COLUMNS);
               crow = tcw_pkg::ROWS - 1;
               scroll_count++;
            end
         end
         tcw_pkg::OP_PUT_AT: begin
            if (on_grid) screen_img[spot] = {attr_now, c.ch};
            else r.rejected = 1'b1;
         end
         tcw_pkg::OP_SET_CURS: begin
            if (on_grid) begin
               crow = int'(c.row);
               ccol = int'(c.col);
            end else begin
               r.rejected = 1'b1;
            end
         end
         tcw_pkg::OP_CLEAR: begin
            blank_range(0, tcw_pkg::CELLS);
            crow = 0;
            ccol = 0;
            clear_count++;
         end
         tcw_pkg::OP_ERASE_BS: begin
            step_left();
            screen_img[crow * tcw_pkg::COLUMNS + ccol] = {attr_now, tcw_pkg::CH_SPACE};
         end
         tcw_pkg::OP_READ_CELL: begin
            if (on_grid) r.cell_word = screen_img[spot];
            else r.rejected = 1'b1;
         end
         default: ;
      endcase
      if (r.rejected) reject_count++;
      r.row = tcw_pkg::ROW_W'(crow);
      r.col = tcw_pkg::COL_W'(ccol);
      r.pos = tcw_pkg::POS_W'(crow * tcw_pkg::COLUMNS + ccol);
      return r;
   endfunction

   function automatic console_cmd_type random_cmd();
      console_cmd_type c;
      int pick;
      c.op  = tcw_pkg::OP_PUT_CHAR;
      c.ch  = tcw_pkg::CHAR_W'($urandom);
      c.row = tcw_pkg::ROW_W'($urandom);
      c.col = tcw_pkg::COL_W'($urandom);
      if ($urandom_range(0, 99) < 85) begin
         c.row = tcw_pkg::ROW_W'(($urandom_range(0, 9) < 4)
                    ? $urandom_range(tcw_pkg::ROWS - 5, tcw_pkg::ROWS - 1)
                    : $urandom_range(0, tcw_pkg::ROWS - 1));
         c.col = tcw_pkg::COL_W'($urandom_range(0, tcw_pkg::COLUMNS - 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         c.ch = tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_SPACE, tcw_pkg::CH_DEL - 1));
      end else if (pick < 68) c.ch = tcw_pkg::CHAR_W'($urandom_range(8'h80, 8'hFF));
      else if (pick < 74) c.ch = tcw_pkg::CH_LF;
      else if (pick < 78) c.ch = tcw_pkg::CH_TAB;
      else if (pick < 81) c.ch = tcw_pkg::CH_CR;
      else if (pick < 85) c.ch = tcw_pkg::CH_BS;
      else if (pick >= 93) c.ch = tcw_pkg::CHAR_W'($urandom_range(0, tcw_pkg::CH_SPACE - 1));
      pick = $urandom_range(0, 99);
      if (pick < 55) c.op = tcw_pkg::OP_PUT_CHAR;
      else if (pick < 65) c.op = tcw_pkg::OP_PUT_AT;
      else if (pick < 75) c.op = tcw_pkg::OP_SET_CURS;
      else if (pick < 77) c.op = tcw_pkg::OP_CLEAR;
      else if (pick < 85) c.op = tcw_pkg::OP_ERASE_BS;
      else if (pick < 97) c.op = tcw_pkg::OP_READ_CELL;
      else c.op = $urandom_range(0, 1) ? OP_NOP_LO : OP_NOP_HI;
      return c;
   endfunction

   task automatic add_cmd(logic [tcw_pkg::OP_W-1:0] op, int unsigned ch,
                          int unsigned row, int unsigned col);
      console_job_type j;
      j.attr_write = 1'b0;
      j.idle_ok    = fill_idle;
      j.attr       = '0;
      j.cmd        = '{op: op, ch: tcw_pkg::CHAR_W'(ch),
                       row: tcw_pkg::ROW_W'(row), col: tcw_pkg::COL_W'(col)};
      pending_jobs.push_back(j);
   endtask

   task automatic add_attr(logic [tcw_pkg::ATTR_W-1:0] value);
      console_job_type j;
      j.attr_write = 1'b1;
      j.idle_ok    = fill_idle;
      j.attr       = value;
      j.cmd        = '0;
      pending_jobs.push_back(j);
   endtask

   task automatic check_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         fault_count++;
         if (fault_count <= SHOW_LIMIT) begin
            $display("result %0d: %s expected 0x%0h, got 0x%0h", rsp_count, label, want, got);
         end
      end
   endtask

   always @(negedge clock) begin
      logic nv_req, nv_csr, calm;
      console_cmd_type c;
      if (!reset) begin
         nv_req = req_tvalid && !req_done;
         nv_csr = csr_valid && !csr_done;
         calm = (pending_jobs.size() == 0) || !pending_jobs[0].idle_ok;
         if (!nv_req && !nv_csr && pending_jobs.size() > 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 8);
            end else if (pending_jobs[0].attr_write) begin
               if (reports_due.size() == 0) begin
                  csr_data <= pending_jobs[0].attr;
                  nv_csr = 1'b1;
                  void'(pending_jobs.pop_front());
               end
            end else begin
               c = pending_jobs[0].cmd;
               req_tdata <= tcw_pkg::REQ_W'({c.col, c.row, c.ch, c.op});
               nv_req = 1'b1;
               void'(pending_jobs.pop_front());
            end
         end
         req_tvalid <= nv_req;
         csr_valid  <= nv_csr;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      console_cmd_type c;
      cursor_report_type got, want;
      bit rsp_done;
      if (reset) begin
         req_done = 1'b0;
         csr_done = 1'b0;
      end else begin
         req_done = req_tvalid && req_tready;
         csr_done = csr_valid && csr_ready;
         rsp_done = rsp_tvalid && rsp_tready;
         if (csr_done) begin
            attr_now = csr_data;
            attr_count++;
         end
         if (req_done) begin
            {c.col, c.row, c.ch, c.op} = req_tdata[tcw_pkg::REQ_BITS-1:0];
            reports_due.push_back(console_apply(c));
            cmd_count++;
         end
         if (rsp_done) begin
            {got.rejected, got.cell_word, got.pos, got.col, got.row} =
               rsp_tdata[tcw_pkg::RSP_BITS-1:0];
            if (reports_due.size() == 0) begin
               fault_count++;
               if (fault_count <= SHOW_LIMIT) begin
                  $display("result %0d arrived with nothing predicted: 0x%0h",
                           rsp_count, rsp_tdata);
               end
            end else begin
               want = reports_due.pop_front();
               check_field("cursor_row", want.row, got.row);
               check_field("cursor_col", want.col, got.col);
               check_field("cursor_pos", want.pos, got.pos);
               check_field("cell_data", want.cell_word, got.cell_word);
               check_field("rejected", want.rejected, got.rejected);
            end
            rsp_count++;
         end
         if (req_done || csr_done || rsp_done) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("no transfer for %0d cycles", STALL_LIMIT);
               $display("text_console_writer_unit test failed");
               $finish;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < tcw_pkg::CELLS; i++) screen_img[i] = tcw_pkg::RESET_CELL;

      add_cmd(tcw_pkg::OP_READ_CELL, $urandom, 0, 0);
      add_cmd(tcw_pkg::OP_PUT_CHAR, 8'h41, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_PUT_CHAR, 8'hFF, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_PUT_CHAR, 8'h80, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CH_DEL, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_PUT_CHAR, 8'h00, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CH_TAB, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CH_CR, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CH_BS, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_ERASE_BS, $urandom, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_READ_CELL, $urandom, 0, 1);
      add_cmd(tcw_pkg::OP_SET_CURS, $urandom, tcw_pkg::ROWS - 1, tcw_pkg::COLUMNS - 1);
      add_cmd(tcw_pkg::OP_PUT_CHAR, 8'h5A, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_SET_CURS, $urandom, tcw_pkg::ROWS - 1, tcw_pkg::COLUMNS - 8);
      add_cmd(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CH_TAB, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CH_BS, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CH_LF, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CH_LF, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_SET_CURS, $urandom, 31, 127);
      add_cmd(tcw_pkg::OP_SET_CURS, $urandom, 0, tcw_pkg::COLUMNS);
      add_cmd(tcw_pkg::OP_PUT_AT, 8'hFE, tcw_pkg::ROWS - 1, tcw_pkg::COLUMNS - 1);
      add_cmd(tcw_pkg::OP_PUT_AT, 8'h1F, tcw_pkg::ROWS, 0);
      add_cmd(tcw_pkg::OP_READ_CELL, $urandom, tcw_pkg::ROWS - 1, tcw_pkg::COLUMNS - 1);
      add_cmd(tcw_pkg::OP_READ_CELL, $urandom, 31, 127);
      add_cmd(OP_NOP_LO, $urandom, $urandom, $urandom);
      add_cmd(OP_NOP_HI, $urandom, $urandom, $urandom);
      add_cmd(tcw_pkg::OP_CLEAR, $urandom, $urandom, $urandom);

      for (int p = 0; p < PHASES; p++) begin
         fill_idle = (p != 2) && (p != PHASES - 1);
         if (p == 0) add_attr(8'hFF);
         else if (p == 1) add_attr(8'h00);
         else add_attr(tcw_pkg::ATTR_W'($urandom));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pending_jobs.push_back('{attr_write: 1'b0, idle_ok: fill_idle,
                                    attr: '0, cmd: random_cmd()});
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_jobs.size() > 0 || req_tvalid || csr_valid) @(posedge clock);
      while (reports_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fault_count += reports_due.size();

      $display("covered %0d commands: %0d scrolls, %0d clears, %0d off-grid coordinates",
               cmd_count, scroll_count, clear_count, reject_count);
      $display("across %0d attribute settings, %0d results checked", attr_count, rsp_count);
      if (fault_count == 0) begin
         $display("text_console_writer_unit test passed");
      end else begin
         $display("%0d mismatches", fault_count);
         $display("text_console_writer_unit test failed");
      end
      $finish;
   end

endmodule
